/* hdl/dice_pkg.sv */
// Shared widths and defaults for the distinct identifier counter.
package dice_pkg;

  localparam int ID_W              = 64;
  localparam int CNT_W             = 16;
  localparam int TABLE_ENTRIES_DEF = 64;

endpackage

/* hdl/dice_if.sv */
// Request and result channel interfaces of the distinct identifier counter.
interface dice_in_if
  import dice_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  space_id;
  logic [CNT_W-1:0] total_count;
  logic             last_item;

  modport source (output valid, output space_id, output total_count, output last_item,
                  input ready);
  modport sink   (input valid, input space_id, input total_count, input last_item,
                  output ready);
endinterface

interface dice_out_if
  import dice_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] distinct_count;

  modport source (output valid, output distinct_count, input ready);
  modport sink   (input valid, input distinct_count, output ready);
endinterface

/* hdl/distinct_id_counter_with_estimate_core.sv */
// Top level of the distinct identifier counter with overflow estimate.
//
// Takes one identifier per request and scans the identifier table, one RAM entry per cycle
// through its single read port; the scan stops early on a hit and is skipped once the estimate
// is formed. A new identifier that meets a full table starts a bit-serial estimate divider.
// The result appears on the last request of a list, is held in an output register, and the
// next request is taken while it waits. The table needs no clearing after reset: only the
// entries below the fill level are ever read.
module distinct_id_counter_with_estimate_core
  import dice_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dice_in_if.sink     in_req,
  dice_out_if.source  out_res
);

  localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW  = $clog2(TABLE_ENTRIES + 1);
  localparam int DVW = CNT_W + FW;
  localparam int DCW = $clog2(DVW + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [FW-1:0]    idx_r, idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0] visited_r, visited_nxt;
  logic             est_done_r, est_done_nxt;
  logic [CNT_W-1:0] running_r, running_nxt;
  logic [DCW-1:0]   div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [ID_W-1:0]  id_r;
  logic [CNT_W-1:0] total_r;
  logic             last_r;
  logic [DVW-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             ram_wr_en, ram_rd_en;
  logic [ID_W-1:0]  ram_rd_data;
  logic             in_fire, hit;
  logic [CNT_W-1:0] visited_inc, rest;
  logic [FW-1:0]    fill_inc;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [DVW-1:0]   quo_step;
  logic [CNT_W-1:0] rem_step;
  logic [DVW:0]     est_sum;
  logic [CNT_W-1:0] est_sat;

  dice_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (id_r),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign in_req.ready           = (state_r == ST_IDLE);
  assign in_fire                = in_req.valid && in_req.ready;
  assign out_res.valid          = out_valid_r;
  assign out_res.distinct_count = out_count_r;

  assign hit         = rd_vld_r && (ram_rd_data == id_r);
  assign ram_rd_en   = (state_r == ST_SCAN) && (idx_r < fill_r) && !hit;
  assign visited_inc = (visited_r == {CNT_W{1'b1}}) ? visited_r : visited_r + 1'b1;
  assign fill_inc    = fill_r + 1'b1;
  assign rest        = (total_r > visited_r) ? total_r - visited_r : '0;

  // one restoring division step per cycle
  assign trial    = {rem_r, quo_r[DVW-1]};
  assign trial_ge = trial >= {1'b0, visited_r};
  assign rem_step = trial_ge ? CNT_W'(trial - {1'b0, visited_r}) : trial[CNT_W-1:0];
  assign quo_step = {quo_r[DVW-2:0], trial_ge};
  assign est_sum  = (DVW+1)'(quo_step) + (DVW+1)'(TABLE_ENTRIES);
  assign est_sat  = (est_sum[DVW:CNT_W] != '0) ? {CNT_W{1'b1}} : est_sum[CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    fill_nxt      = fill_r;
    visited_nxt   = visited_r;
    est_done_nxt  = est_done_r;
    running_nxt   = running_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    out_count_nxt = out_count_r;
    ram_wr_en     = 1'b0;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = '0;
          state_nxt = est_done_r ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ram_rd_en) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (hit) begin
          visited_nxt = visited_inc;
          state_nxt   = ST_FINISH;
        end else if (!rd_vld_r && idx_r == fill_r) begin
          if (fill_r < FW'(TABLE_ENTRIES)) begin
            ram_wr_en   = 1'b1;
            fill_nxt    = fill_inc;
            running_nxt = CNT_W'(fill_inc);
            visited_nxt = visited_inc;
            state_nxt   = ST_FINISH;
          end else if (visited_r == '0) begin
            running_nxt  = CNT_W'(TABLE_ENTRIES);
            est_done_nxt = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            quo_nxt     = DVW'(rest) * DVW'(TABLE_ENTRIES);
            rem_nxt     = '0;
            div_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_nxt     = quo_step;
        rem_nxt     = rem_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCW'(DVW - 1)) begin
          running_nxt  = est_sat;
          est_done_nxt = 1'b1;
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_res.ready) begin
          // deliver the list result and clear for the next list
          out_valid_nxt = 1'b1;
          out_count_nxt = (total_r < CNT_W'(2)) ? CNT_W'(1) : running_r;
          fill_nxt      = '0;
          visited_nxt   = '0;
          est_done_nxt  = 1'b0;
          running_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      fill_r      <= '0;
      visited_r   <= '0;
      est_done_r  <= 1'b0;
      running_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fill_r      <= fill_nxt;
      visited_r   <= visited_nxt;
      est_done_r  <= est_done_nxt;
      running_r   <= running_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r    <= in_req.space_id;
      total_r <= in_req.total_count;
      last_r  <= in_req.last_item;
    end
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    out_count_r <= out_count_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  a_div_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> fill_r == FW'(TABLE_ENTRIES) && !est_done_r)
    else $error("division running without a full table");

  a_est_floor: assert property (@(posedge clk) disable iff (!rst_n)
    est_done_r |-> running_r >= CNT_W'(TABLE_ENTRIES))
    else $error("estimate below table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("request accepted without work");

endmodule

/* hdl/dice_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dice_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
